// ----- design/multilevel_priority_fifo_defines.svh -----
`ifndef MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MPQ_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MPQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/mpq_pkg.sv -----
package mpq_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 64;
    localparam int ID_WIDTH    = 16;

    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int LVL_W     = $clog2(NUM_LEVELS + 1);
    localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int FILL_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W    = $clog2(NUM_LEVELS * LEVEL_DEPTH);
    localparam int TOT_W     = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);

    localparam int REQ_W       = 2;
    localparam int LEVEL_W     = 4;
    localparam int CFG_W       = 4;
    localparam int TOTAL_OUT_W = 10;
    localparam int COUNT_OUT_W = 7;
    localparam int STAT_W      = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADLEVEL = 2'd3;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [ID_WIDTH-1:0] task_id;
        logic [LEVEL_W-1:0]  task_level;
        logic [LEVEL_W-1:0]  query_level;
    } req_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]    head_id;
        logic [LEVEL_W-1:0]     head_level;
        logic                   all_empty;
        logic [TOTAL_OUT_W-1:0] total_count;
        logic [COUNT_OUT_W-1:0] level_count;
        logic [STAT_W-1:0]      status;
    } res_t;

endpackage

// ----- design/mpq_store.sv -----
module mpq_store
    import mpq_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [ID_WIDTH-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [ID_WIDTH-1:0] rd_data
);

    logic [ID_WIDTH-1:0] mem [NUM_LEVELS*LEVEL_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mpq_ctrl.sv -----
`include "multilevel_priority_fifo_defines.svh"

module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    input  logic [CFG_W-1:0] active_levels,
    output logic             res_valid,
    input  logic             res_take,
    output res_t             res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [PTR_W-1:0]  head_ptr_reg [NUM_LEVELS];
    logic [PTR_W-1:0]  head_ptr_next [NUM_LEVELS];
    logic [PTR_W-1:0]  tail_ptr_reg [NUM_LEVELS];
    logic [PTR_W-1:0]  tail_ptr_next [NUM_LEVELS];
    logic [FILL_W-1:0] fill_reg [NUM_LEVELS];
    logic [FILL_W-1:0] fill_next [NUM_LEVELS];
    logic [TOT_W-1:0]  grand_total_reg, grand_total_next;

    logic [STAT_W-1:0]  status_reg, status_next;
    logic [LEVEL_W-1:0] qlev_reg, qlev_next;
    logic [LVL_W-1:0]   lv_reg, lv_next;
    logic [LEVEL_W-1:0] hlev_reg, hlev_next;
    logic               found_reg, found_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [FILL_W-1:0]  lcount_reg, lcount_next;

    logic [LVL_W-1:0]     eff_lv;
    logic [LVL_W-1:0]     use_lv;
    logic                 acc;
    logic                 push_ok;
    logic [LVL_IDX_W-1:0] lev_idx;
    logic                 top_found;
    logic [LVL_IDX_W-1:0] top_idx;
    logic [TOT_W-1:0]     hidden;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ID_WIDTH-1:0] rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(LEVEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_IDX_W-1:0] l,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p));
    endfunction

    mpq_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.task_id),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign eff_lv    = (active_levels > NUM_LEVELS) ? LVL_W'(NUM_LEVELS) : LVL_W'(active_levels);
    assign acc       = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign lev_idx   = LVL_IDX_W'(req.task_level - 1'b1);
    assign use_lv    = (state_reg == S_IDLE) ? eff_lv : lv_reg;

    always_comb
    begin
        top_found = 1'b0;
        top_idx   = '0;
        hidden    = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (i < use_lv)
            begin
                if (fill_reg[i] != '0)
                begin
                    top_found = 1'b1;
                    top_idx   = LVL_IDX_W'(i);
                end
            end
            else
            begin
                hidden = hidden + TOT_W'(fill_reg[i]);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        fill_next        = fill_reg;
        grand_total_next = grand_total_reg;
        status_next      = status_reg;
        qlev_next        = qlev_reg;
        lv_next          = lv_reg;
        hlev_next        = hlev_reg;
        found_next       = found_reg;
        total_next       = total_reg;
        lcount_next      = lcount_reg;
        push_ok          = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = mem_addr(lev_idx, tail_ptr_reg[lev_idx]);
        rd_en            = 1'b0;
        rd_addr          = mem_addr(top_idx, head_ptr_reg[top_idx]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    qlev_next   = req.query_level;
                    lv_next     = eff_lv;
                    status_next = ST_OK;
                    state_next  = S_READ;
                    priority if (req.req_type == REQ_PUSH)
                    begin
                        if (req.task_level == '0 || req.task_level > eff_lv)
                        begin
                            status_next = ST_BADLEVEL;
                        end
                        else if (fill_reg[lev_idx] == FILL_W'(LEVEL_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            push_ok                = 1'b1;
                            wr_en                  = 1'b1;
                            tail_ptr_next[lev_idx] = ptr_inc(tail_ptr_reg[lev_idx]);
                            fill_next[lev_idx]     = fill_reg[lev_idx] + 1'b1;
                            grand_total_next       = grand_total_reg + 1'b1;
                        end
                    end
                    else if (req.req_type == REQ_POP)
                    begin
                        if (!top_found)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            head_ptr_next[top_idx] = ptr_inc(head_ptr_reg[top_idx]);
                            fill_next[top_idx]     = fill_reg[top_idx] - 1'b1;
                            grand_total_next       = grand_total_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            end
            S_READ:
            begin
                rd_en       = 1'b1;
                found_next  = top_found;
                hlev_next   = top_found ? LEVEL_W'(top_idx) + LEVEL_W'(1) : '0;
                total_next  = grand_total_reg - hidden;
                lcount_next = '0;
                if (qlev_reg != '0 && qlev_reg <= lv_reg)
                begin
                    lcount_next = fill_reg[LVL_IDX_W'(qlev_reg - 1'b1)];
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            grand_total_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_ptr_reg[i] <= '0;
                tail_ptr_reg[i] <= '0;
                fill_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            grand_total_reg <= grand_total_next;
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            fill_reg        <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        qlev_reg   <= qlev_next;
        lv_reg     <= lv_next;
        hlev_reg   <= hlev_next;
        found_reg  <= found_next;
        total_reg  <= total_next;
        lcount_reg <= lcount_next;
    end

    assign res_valid       = (state_reg == S_RESP);
    assign res.head_id     = found_reg ? rd_data : '0;
    assign res.head_level  = hlev_reg;
    assign res.all_empty   = !found_reg;
    assign res.total_count = TOTAL_OUT_W'(total_reg);
    assign res.level_count = COUNT_OUT_W'(lcount_reg);
    assign res.status      = status_reg;

    `MPQ_ASSERT_NEXT(a_push_count, acc && push_ok, grand_total_reg == $past(grand_total_reg) + 1'b1, "push did not raise total")
    `MPQ_ASSERT_IMPL(a_empty_head, res_valid, res.all_empty == (res.head_level == '0), "empty flag and head level disagree")
    `MPQ_ASSERT_IMPL(a_pop_empty, res_valid && res.status == ST_EMPTY, res.all_empty, "failed pop left a task visible")

endmodule

// ----- design/multilevel_priority_fifo.sv -----
// channel  | handshake             | payload
// request  | in_valid / in_stall   | req_type, task_id, task_level, query_level
// result   | out_valid / out_stall | head_id, head_level, all_empty, total_count,
//          |                       | level_count, status
// config   | cfg_valid / cfg_ready | active_levels
//
// Each request goes through these steps in order: accept with pointer update and store write,
// head read from the entry store, result load into the output register.
// A request is held off while the previous one is in flight.
// A result waiting on out_stall holds the sequencer in its last step.
// Reset clears all pointers and counts at once; active_levels resets to 8.
module multilevel_priority_fifo
    import mpq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [ID_WIDTH-1:0]    task_id,
    input  logic [LEVEL_W-1:0]     task_level,
    input  logic [LEVEL_W-1:0]     query_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ID_WIDTH-1:0]    head_id,
    output logic [LEVEL_W-1:0]     head_level,
    output logic                   all_empty,
    output logic [TOTAL_OUT_W-1:0] total_count,
    output logic [COUNT_OUT_W-1:0] level_count,
    output logic [STAT_W-1:0]      status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       active_levels
);

    logic [CFG_W-1:0] active_levels_reg;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg;
    req_t             req;
    res_t             res;
    logic             res_valid;
    logic             res_take;

    assign req.req_type    = req_type;
    assign req.task_id     = task_id;
    assign req.task_level  = task_level;
    assign req.query_level = query_level;

    mpq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (in_valid),
        .req_stall     (in_stall),
        .req           (req),
        .active_levels (active_levels_reg),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_levels_reg <= ACTIVE_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_levels_reg <= active_levels;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign head_id     = out_res_reg.head_id;
    assign head_level  = out_res_reg.head_level;
    assign all_empty   = out_res_reg.all_empty;
    assign total_count = out_res_reg.total_count;
    assign level_count = out_res_reg.level_count;
    assign status      = out_res_reg.status;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import mpq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 105;
    localparam int PHASE_ACTIVE [PHASES]   = '{15, 1, 8, 0, 3, 2, 8, 5};
    localparam int PHASE_PUSH_PCT [PHASES] = '{60, 92, 55, 50, 45, 70, 30, 50};

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    typedef struct {
        req_t rq;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [REQ_W-1:0]       req_type = '0;
    logic [ID_WIDTH-1:0]    task_id = '0;
    logic [LEVEL_W-1:0]     task_level = '0;
    logic [LEVEL_W-1:0]     query_level = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [ID_WIDTH-1:0]    head_id;
    logic [LEVEL_W-1:0]     head_level;
    logic                   all_empty;
    logic [TOTAL_OUT_W-1:0] total_count;
    logic [COUNT_OUT_W-1:0] level_count;
    logic [STAT_W-1:0]      status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       active_levels = ACTIVE_RESET;

    logic [ID_WIDTH-1:0] id_slot [NUM_LEVELS][LEVEL_DEPTH];
    int                  rd_ptr [NUM_LEVELS] = '{default: 0};
    int                  wr_ptr [NUM_LEVELS] = '{default: 0};
    int                  fill [NUM_LEVELS]   = '{default: 0};
    int                  lvl_limit = int'(ACTIVE_RESET);

    res_t  pending_snapshots [$];
    pace_t pace = PACE_FULL;
    int    errors = 0;
    int    cycles = 0;
    int    n_requests = 0;
    int    n_full = 0;
    int    n_bad = 0;
    int    n_empty_pop = 0;

    dir_row_t dir_rows [18] = '{
        '{'{REQ_QUERY, 16'h0000, 4'd0, 4'd3}, 1'b1, '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_OK}},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd0}, 1'b1, '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_EMPTY}},
        '{'{REQ_PUSH, 16'h5a5a, 4'd0, 4'd1}, 1'b1,
          '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_BADLEVEL}},
        '{'{REQ_PUSH, 16'hffff, 4'd9, 4'd8}, 1'b1,
          '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_BADLEVEL}},
        '{'{REQ_PUSH, 16'h0000, 4'd15, 4'd15}, 1'b1,
          '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_BADLEVEL}},
        '{'{REQ_PUSH, 16'hffff, 4'd8, 4'd8}, 1'b1, '{16'hffff, 4'd8, 1'b0, 10'd1, 7'd1, ST_OK}},
        '{'{REQ_PUSH, 16'h0000, 4'd1, 4'd1}, 1'b0, '0},
        '{'{REQ_PUSH, 16'h8001, 4'd1, 4'd0}, 1'b0, '0},
        '{'{REQ_PUSH, 16'h1234, 4'd8, 4'd15}, 1'b0, '0},
        '{'{REQ_SPARE, 16'h7fff, 4'd3, 4'd8}, 1'b0, '0},
        '{'{REQ_QUERY, 16'h0000, 4'd1, 4'd9}, 1'b0, '0},
        '{'{REQ_QUERY, 16'hffff, 4'd0, 4'd1}, 1'b0, '0},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd8}, 1'b0, '0},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd8}, 1'b0, '0},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd1}, 1'b0, '0},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd1}, 1'b0, '0},
        '{'{REQ_POP, 16'h0000, 4'd0, 4'd1}, 1'b1, '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_EMPTY}},
        '{'{REQ_QUERY, 16'h0000, 4'd0, 4'd8}, 1'b1, '{16'h0000, 4'd0, 1'b1, 10'd0, 7'd0, ST_OK}}
    };

    multilevel_priority_fifo dut (.*);

    always #4 clk = ~clk;

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int used_levels();
        return (lvl_limit > NUM_LEVELS) ? NUM_LEVELS : lvl_limit;
    endfunction

    function automatic int top_busy_level(int lv);
        for (int i = lv - 1; i >= 0; i--)
        begin
            if (fill[i] != 0)
                return i;
        end
        return -1;
    endfunction

    function automatic res_t snapshot_after(req_t r);
        res_t o;
        int   lv;
        int   top;
        int   sum;
        o = '0;
        lv = used_levels();
        if (r.req_type == REQ_PUSH)
        begin
            if (r.task_level == 0 || int'(r.task_level) > lv)
                o.status = ST_BADLEVEL;
            else if (fill[r.task_level - 1] == LEVEL_DEPTH)
                o.status = ST_FULL;
            else
            begin
                top = int'(r.task_level) - 1;
                id_slot[top][wr_ptr[top]] = r.task_id;
                wr_ptr[top] = (wr_ptr[top] + 1) % LEVEL_DEPTH;
                fill[top]++;
            end
        end
        else if (r.req_type == REQ_POP)
        begin
            top = top_busy_level(lv);
            if (top < 0)
                o.status = ST_EMPTY;
            else
            begin
                rd_ptr[top] = (rd_ptr[top] + 1) % LEVEL_DEPTH;
                fill[top]--;
            end
        end
        sum = 0;
        for (int i = 0; i < lv; i++)
            sum += fill[i];
        o.total_count = TOTAL_OUT_W'(sum);
        if (r.query_level >= 1 && int'(r.query_level) <= lv)
            o.level_count = COUNT_OUT_W'(fill[r.query_level - 1]);
        top = top_busy_level(lv);
        o.all_empty = (top < 0);
        if (top >= 0)
        begin
            o.head_id = id_slot[top][rd_ptr[top]];
            o.head_level = LEVEL_W'(top + 1);
        end
        return o;
    endfunction

    function automatic req_t random_request(int push_pct);
        req_t r;
        int   lv;
        int   pick;
        lv = used_levels();
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            r.req_type = REQ_PUSH;
        else if (pick < push_pct + (100 - push_pct) * 3 / 4)
            r.req_type = REQ_POP;
        else
            r.req_type = coin(80) ? REQ_QUERY : REQ_SPARE;
        case ($urandom_range(0, 15))
            0:       r.task_id = '0;
            1:       r.task_id = '1;
            default: r.task_id = ID_WIDTH'($urandom);
        endcase
        if (lv > 0 && coin(85))
            r.task_level = LEVEL_W'($urandom_range(1, lv));
        else
            r.task_level = LEVEL_W'($urandom_range(0, 15));
        if (lv > 0 && coin(60))
            r.query_level = LEVEL_W'($urandom_range(1, lv));
        else
            r.query_level = LEVEL_W'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_request(req_t r, bit typed, res_t want);
        res_t pred;
        while ((pace == PACE_SEND_IDLE && coin(55)) || (pace == PACE_BOTH && coin(37)))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= r.req_type;
        task_id     <= r.task_id;
        task_level  <= r.task_level;
        query_level <= r.query_level;
        do @(posedge clk); while (in_stall);
        pred = snapshot_after(r);
        pending_snapshots.push_back(typed ? want : pred);
        n_requests++;
        if (pred.status == ST_FULL)
            n_full++;
        if (pred.status == ST_BADLEVEL)
            n_bad++;
        if (pred.status == ST_EMPTY)
            n_empty_pop++;
    endtask

    task automatic set_active_levels(int v);
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid     <= 1'b1;
        active_levels <= CFG_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lvl_limit = v;
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n)
        begin
            out_stall <= (pace == PACE_RECV_STALL && coin(55)) || (pace == PACE_BOTH && coin(37));
            if (out_valid && !out_stall)
            begin
                if (pending_snapshots.size() == 0)
                begin
                    $error("result arrived with no request pending");
                    errors++;
                end
                else
                begin
                    want = pending_snapshots.pop_front();
                    check_field("head_id", want.head_id, head_id);
                    check_field("head_level", want.head_level, head_level);
                    check_field("all_empty", want.all_empty, all_empty);
                    check_field("total_count", want.total_count, total_count);
                    check_field("level_count", want.level_count, level_count);
                    check_field("status", want.status, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        in_valid <= 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_active_levels(PHASE_ACTIVE[p]);
            pace = pace_t'(p % 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(PHASE_PUSH_PCT[p]), 1'b0, '0);
            in_valid <= 1'b0;
        end
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d requests across %0d active_levels settings, 0 and 15 among them",
                 n_requests, PHASES);
        $display("pushes to a full level %0d, pushes to a bad level %0d, pops while empty %0d",
                 n_full, n_bad, n_empty_pop);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
